@@ hw/rtl/sfa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sfa_pkg;

  // Sizes of the block.
  localparam int MAX_LABELS = 16;
  localparam int MAX_FOLDS  = 16;
  localparam int COUNT_BITS = 20;

  localparam int LABEL_W = 4;              // class label and label index
  localparam int FOLD_W  = 4;              // fold index
  localparam int CFG_W   = 5;              // fold and label count registers
  localparam int OFF_W   = 8;              // stored label offset, below F <= 256
  localparam int DVD_W   = 14;             // dividend, holds inc * (I + 1) <= 4352
  localparam int DVS_W   = 9;              // divisor, up to F = 256
  localparam int REM_W   = 8;              // remainder, below the divisor
  localparam int DIV_CYC = DVD_W / 2;      // two quotient bits per cycle
  localparam int DIV_CNT_W = $clog2(DIV_CYC);
  localparam int STEP_W  = 4;              // microprogram address

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_INNER  = 2'd0,
    REG_OUTER  = 2'd1,
    REG_LABELS = 2'd2,
    REG_TOTAL  = 2'd3
  } cfg_reg_t;

  // Dividend source select.
  typedef enum logic [2:0] {
    DVD_NF,
    DVD_PROD,
    DVD_MEM,
    DVD_OFF,
    DVD_OFF_STRIDE
  } dvd_sel_t;

  // Divisor source select.
  typedef enum logic [1:0] {
    DVS_NL,
    DVS_NF,
    DVS_NI
  } dvs_sel_t;

  // Datapath action of a microinstruction.
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_INC,
    ACT_FILL,
    ACT_SEED,
    ACT_OFF,
    ACT_FOLDS,
    ACT_COUNT,
    ACT_STORE,
    ACT_ERR
  } act_t;

  // Sequencing of a microinstruction.
  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_WAIT,
    JMP_LOOP,
    JMP_BAD,
    JMP_END
  } jmp_t;

  typedef struct packed {
    logic              div_go;
    dvd_sel_t          dvd;
    dvs_sel_t          dvs;
    act_t              act;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic  fire;
    ctrl_t ctrl;
  } seq_cmd_t;

  typedef struct packed {
    logic div_idle;
    logic bad_label;
    logic last_label;
  } dp_status_t;

  typedef struct packed {
    logic [FOLD_W-1:0]     inner_fold;
    logic [FOLD_W-1:0]     outer_fold;
    logic [COUNT_BITS-1:0] inner_remaining;
    logic [COUNT_BITS-1:0] outer_remaining;
    logic                  label_error;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/sfa_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sfa_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [sfa_pkg::DVD_W-1:0]  dividend,
  input  logic [sfa_pkg::DVS_W-1:0]  divisor,
  output logic                       idle,
  output logic [sfa_pkg::DVD_W-1:0]  quo,
  output logic [sfa_pkg::REM_W-1:0]  rem
);
  import sfa_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DVD_W-1:0]     q;
  logic [REM_W-1:0]     r;
  logic [DVS_W-1:0]     d;

  logic [DVS_W-1:0] r2a, r2b;
  logic             ge_a, ge_b;
  logic [REM_W-1:0] ra, rb;
  logic [DVD_W-1:0] qa, qb;

  // Two restoring steps per cycle.
  always_comb begin
    r2a  = {r, q[DVD_W-1]};
    ge_a = (r2a >= d);
    ra   = ge_a ? REM_W'(r2a - d) : REM_W'(r2a);
    qa   = {q[DVD_W-2:0], ge_a};
    r2b  = {ra, qa[DVD_W-1]};
    ge_b = (r2b >= d);
    rb   = ge_b ? REM_W'(r2b - d) : REM_W'(r2b);
    qb   = {qa[DVD_W-2:0], ge_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (go) begin
      busy <= 1'b1;
      cnt  <= '0;
      q    <= dividend;
      r    <= '0;
      d    <= divisor;
    end else if (busy) begin
      q   <= qb;
      r   <= rb;
      cnt <= cnt + DIV_CNT_W'(1);
      if (cnt == DIV_CNT_W'(DIV_CYC - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign idle = !busy;
  assign quo  = q;
  assign rem  = r;

endmodule

`default_nettype wire

@@ hw/rtl/sfa_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sfa_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [1:0]                      cfg_index,
  input  logic [sfa_pkg::COUNT_BITS-1:0]  cfg_data,
  input  logic                            start,
  input  logic [sfa_pkg::LABEL_W-1:0]     class_label,
  input  sfa_pkg::seq_cmd_t               cmd,
  output sfa_pkg::dp_status_t             status,
  output logic                            emit,
  output sfa_pkg::result_t                result
);
  import sfa_pkg::*;

  function automatic logic [CFG_W-1:0] clamp_cnt(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] hi);
    if (v == '0) return CFG_W'(1);
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [COUNT_BITS-1:0] dec_sat(input logic [COUNT_BITS-1:0] v);
    return (v == '0) ? v : v - COUNT_BITS'(1);
  endfunction

  // Configuration registers.
  logic [CFG_W-1:0]      inner_cfg, outer_cfg, label_cfg;
  logic [COUNT_BITS-1:0] total;

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_cfg <= CFG_W'(1);
      outer_cfg <= CFG_W'(1);
      label_cfg <= CFG_W'(1);
      total     <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_INNER:  inner_cfg <= cfg_data[CFG_W-1:0];
        REG_OUTER:  outer_cfg <= cfg_data[CFG_W-1:0];
        REG_LABELS: label_cfg <= cfg_data[CFG_W-1:0];
        REG_TOTAL:  total     <= cfg_data;
        default:    total     <= total;
      endcase
    end
  end

  logic [CFG_W-1:0]   ni, no, nl, stride;
  logic [2*CFG_W-1:0] nf_full;
  logic [DVS_W-1:0]   nf;

  assign ni      = clamp_cnt(inner_cfg, CFG_W'(MAX_FOLDS));
  assign no      = clamp_cnt(outer_cfg, CFG_W'(MAX_FOLDS));
  assign nl      = clamp_cnt(label_cfg, CFG_W'(MAX_LABELS));
  assign nf_full = (2*CFG_W)'(ni) * (2*CFG_W)'(no);
  assign nf      = nf_full[DVS_W-1:0];
  assign stride  = ni + CFG_W'(1);

  // Working registers.
  logic [DVS_W-1:0]   inc;
  logic [REM_W-1:0]   step;
  logic [OFF_W-1:0]   seed;
  logic [LABEL_W-1:0] k;
  logic [OFF_W-1:0]   off;
  logic [FOLD_W-1:0]  fi, fo;
  logic [LABEL_W-1:0] lab;

  logic [OFF_W-1:0]      label_offset [MAX_LABELS];
  logic [COUNT_BITS-1:0] inner_left   [MAX_FOLDS];
  logic [COUNT_BITS-1:0] outer_left   [MAX_FOLDS];

  // Divider and its operand selection.
  logic [DVD_W-1:0] dividend, prod, quo;
  logic [DVS_W-1:0] divisor;
  logic [REM_W-1:0] rem;
  logic [OFF_W:0]   off_stride;
  logic             div_idle;

  assign prod       = DVD_W'(inc) * DVD_W'(stride);
  assign off_stride = (OFF_W+1)'(off) + (OFF_W+1)'(stride);

  always_comb begin
    unique case (cmd.ctrl.dvd)
      DVD_NF:         dividend = DVD_W'(nf);
      DVD_PROD:       dividend = prod;
      DVD_MEM:        dividend = DVD_W'(label_offset[lab]);
      DVD_OFF:        dividend = DVD_W'(off);
      DVD_OFF_STRIDE: dividend = DVD_W'(off_stride);
      default:        dividend = '0;
    endcase
    unique case (cmd.ctrl.dvs)
      DVS_NL:  divisor = DVS_W'(nl);
      DVS_NF:  divisor = nf;
      DVS_NI:  divisor = DVS_W'(ni);
      default: divisor = nf;
    endcase
  end

  sfa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.fire && cmd.ctrl.div_go),
    .dividend (dividend),
    .divisor  (divisor),
    .idle     (div_idle),
    .quo      (quo),
    .rem      (rem)
  );

  // Next seed offset: the previous one plus the step, wrapped once at F.
  logic [OFF_W:0]   seed_sum;
  logic [OFF_W-1:0] seed_next;

  assign seed_sum  = (OFF_W+1)'(seed) + (OFF_W+1)'(step);
  assign seed_next = (seed_sum >= nf) ? OFF_W'(seed_sum - nf) : OFF_W'(seed_sum);

  logic do_seed, do_fill, do_count, do_store;

  assign do_seed  = cmd.fire && (cmd.ctrl.act == ACT_SEED);
  assign do_fill  = cmd.fire && (cmd.ctrl.act == ACT_FILL);
  assign do_count = cmd.fire && (cmd.ctrl.act == ACT_COUNT);
  assign do_store = cmd.fire && (cmd.ctrl.act == ACT_STORE);

  always_ff @(posedge clk) begin
    if (start) begin
      lab <= class_label;
    end
    if (cmd.fire) begin
      case (cmd.ctrl.act)
        ACT_INC:   inc <= (quo[DVS_W-1:0] == '0) ? DVS_W'(1) : quo[DVS_W-1:0];
        ACT_FILL: begin
          step <= rem;
          seed <= '0;
          k    <= '0;
        end
        ACT_SEED: begin
          seed <= seed_next;
          k    <= k + LABEL_W'(1);
        end
        ACT_OFF:   off <= rem;
        ACT_FOLDS: begin
          fi <= rem[FOLD_W-1:0];
          fo <= quo[FOLD_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_LABELS; i++) begin
        label_offset[i] <= '0;
      end
    end else if (do_seed) begin
      label_offset[k] <= ({1'b0, k} < nl) ? seed : '0;
    end else if (do_store) begin
      label_offset[lab] <= rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_FOLDS; i++) begin
        inner_left[i] <= '0;
        outer_left[i] <= '0;
      end
    end else if (do_fill) begin
      for (int i = 0; i < MAX_FOLDS; i++) begin
        inner_left[i] <= total;
        outer_left[i] <= total;
      end
    end else if (do_count) begin
      inner_left[fi] <= dec_sat(inner_left[fi]);
      if (no > CFG_W'(1)) begin
        outer_left[fo] <= dec_sat(outer_left[fo]);
      end
    end
  end

  assign status.div_idle   = div_idle;
  assign status.bad_label  = ({1'b0, lab} >= nl);
  assign status.last_label = (k == LABEL_W'(MAX_LABELS - 1));

  assign emit = do_store || (cmd.fire && (cmd.ctrl.act == ACT_ERR));

  always_comb begin
    if (cmd.ctrl.act == ACT_ERR) begin
      result = '0;
      result.label_error = 1'b1;
    end else begin
      result.inner_fold      = fi;
      result.outer_fold      = fo;
      result.inner_remaining = inner_left[fi];
      result.outer_remaining = outer_left[fo];
      result.label_error     = 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sfa_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sfa_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                start_mode,
  input  sfa_pkg::dp_status_t status,
  input  logic                out_free,
  output sfa_pkg::seq_cmd_t   cmd,
  output logic                busy
);
  import sfa_pkg::*;

  // Microprogram addresses.
  localparam logic [STEP_W-1:0] S_R_DIV1  = STEP_W'(0);
  localparam logic [STEP_W-1:0] S_R_INC   = STEP_W'(1);
  localparam logic [STEP_W-1:0] S_R_DIV2  = STEP_W'(2);
  localparam logic [STEP_W-1:0] S_R_FILL  = STEP_W'(3);
  localparam logic [STEP_W-1:0] S_R_SEED  = STEP_W'(4);
  localparam logic [STEP_W-1:0] S_R_END   = STEP_W'(5);
  localparam logic [STEP_W-1:0] S_A_CHK   = STEP_W'(6);
  localparam logic [STEP_W-1:0] S_A_DIV1  = STEP_W'(7);
  localparam logic [STEP_W-1:0] S_A_OFF   = STEP_W'(8);
  localparam logic [STEP_W-1:0] S_A_DIV2  = STEP_W'(9);
  localparam logic [STEP_W-1:0] S_A_FOLDS = STEP_W'(10);
  localparam logic [STEP_W-1:0] S_A_CNT   = STEP_W'(11);
  localparam logic [STEP_W-1:0] S_A_STORE = STEP_W'(12);
  localparam logic [STEP_W-1:0] S_A_END   = STEP_W'(13);
  localparam logic [STEP_W-1:0] S_A_ERR   = STEP_W'(14);

  function automatic ctrl_t rom(input logic [STEP_W-1:0] a);
    ctrl_t w;
    unique case (a)
      S_R_DIV1:  w = '{1'b1, DVD_NF,         DVS_NL, ACT_NONE,  JMP_NEXT, S_R_DIV1};
      S_R_INC:   w = '{1'b0, DVD_NF,         DVS_NL, ACT_INC,   JMP_WAIT, S_R_DIV1};
      S_R_DIV2:  w = '{1'b1, DVD_PROD,       DVS_NF, ACT_NONE,  JMP_NEXT, S_R_DIV1};
      S_R_FILL:  w = '{1'b0, DVD_PROD,       DVS_NF, ACT_FILL,  JMP_WAIT, S_R_DIV1};
      S_R_SEED:  w = '{1'b0, DVD_NF,         DVS_NF, ACT_SEED,  JMP_LOOP, S_R_SEED};
      S_R_END:   w = '{1'b0, DVD_NF,         DVS_NF, ACT_NONE,  JMP_END,  S_R_DIV1};
      S_A_CHK:   w = '{1'b0, DVD_MEM,        DVS_NF, ACT_NONE,  JMP_BAD,  S_A_ERR};
      S_A_DIV1:  w = '{1'b1, DVD_MEM,        DVS_NF, ACT_NONE,  JMP_NEXT, S_R_DIV1};
      S_A_OFF:   w = '{1'b0, DVD_MEM,        DVS_NF, ACT_OFF,   JMP_WAIT, S_R_DIV1};
      S_A_DIV2:  w = '{1'b1, DVD_OFF,        DVS_NI, ACT_NONE,  JMP_NEXT, S_R_DIV1};
      S_A_FOLDS: w = '{1'b0, DVD_OFF,        DVS_NI, ACT_FOLDS, JMP_WAIT, S_R_DIV1};
      S_A_CNT:   w = '{1'b1, DVD_OFF_STRIDE, DVS_NF, ACT_COUNT, JMP_NEXT, S_R_DIV1};
      S_A_STORE: w = '{1'b0, DVD_OFF_STRIDE, DVS_NF, ACT_STORE, JMP_WAIT, S_R_DIV1};
      S_A_END:   w = '{1'b0, DVD_NF,         DVS_NF, ACT_NONE,  JMP_END,  S_R_DIV1};
      S_A_ERR:   w = '{1'b0, DVD_NF,         DVS_NF, ACT_ERR,   JMP_END,  S_R_DIV1};
      default:   w = '{1'b0, DVD_NF,         DVS_NF, ACT_NONE,  JMP_END,  S_R_DIV1};
    endcase
    return w;
  endfunction

  logic [STEP_W-1:0] pc, pc_next;
  logic              busy_next;
  ctrl_t             ctrl;
  logic              emitting, proceed;

  assign ctrl     = rom(pc);
  assign emitting = (ctrl.act == ACT_STORE) || (ctrl.act == ACT_ERR);
  // A wait step holds while the divider runs, and an emitting step while its result has nowhere to go.
  assign proceed  = busy && ((ctrl.jmp != JMP_WAIT) || status.div_idle) &&
                    (!emitting || out_free);

  assign cmd.fire = proceed;
  assign cmd.ctrl = ctrl;

  always_comb begin
    pc_next   = pc;
    busy_next = busy;
    if (start) begin
      busy_next = 1'b1;
      pc_next   = start_mode ? S_A_CHK : S_R_DIV1;
    end else if (proceed) begin
      unique case (ctrl.jmp) inside
        JMP_NEXT, JMP_WAIT: pc_next = pc + STEP_W'(1);
        JMP_LOOP: pc_next = status.last_label ? pc + STEP_W'(1) : ctrl.target;
        JMP_BAD:  pc_next = status.bad_label ? ctrl.target : pc + STEP_W'(1);
        default:  busy_next = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= S_R_DIV1;
      busy <= 1'b0;
    end else begin
      pc   <= pc_next;
      busy <= busy_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/stratified_fold_assigner.sv @@
// An assign transfer shows one result, and the next item is taken only once its microprogram
// has ended; a bad label gives a result with label_error set. A restart gives no result.
// The three divisions of an assign run on one shared two-bit-per-cycle divider; the restart
// seeds one label per cycle.
// Reset (rst, synchronous, active high) sets the fold and label counts to 1, the sample total
// to 0, and clears all label offsets and remaining counts.
`timescale 1ns / 1ps
`default_nettype none

module stratified_fold_assigner (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port.
  input  logic                            cfg_write_en,
  input  logic [1:0]                      cfg_index,
  input  logic [sfa_pkg::COUNT_BITS-1:0]  cfg_data,
  // Item channel.
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic                            mode,
  input  logic [sfa_pkg::LABEL_W-1:0]     class_label,
  // Result channel.
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [sfa_pkg::FOLD_W-1:0]      inner_fold,
  output logic [sfa_pkg::FOLD_W-1:0]      outer_fold,
  output logic [sfa_pkg::COUNT_BITS-1:0]  inner_remaining,
  output logic [sfa_pkg::COUNT_BITS-1:0]  outer_remaining,
  output logic                            label_error
);
  import sfa_pkg::*;

  // The sequencer steps through a small microprogram held in a ROM; each control word
  // selects divider operands, a datapath action and how the step counter moves on.
  // The input side stalls exactly while the microprogram is running.
  logic       seq_busy;
  logic       item_accept;
  logic       out_free;
  logic       emit;
  seq_cmd_t   cmd;
  dp_status_t status;
  result_t    result;

  assign item_stall  = seq_busy;
  assign item_accept = item_valid && !item_stall;

  // The output register can take a new result when it is empty or is being drained by
  // a transfer in the same cycle; otherwise the emitting step holds and new items stall.
  assign out_free = !result_valid || !result_stall;

  sfa_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (item_accept),
    .start_mode (mode),
    .status     (status),
    .out_free   (out_free),
    .cmd        (cmd),
    .busy       (seq_busy)
  );

  sfa_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .start        (item_accept),
    .class_label  (class_label),
    .cmd          (cmd),
    .status       (status),
    .emit         (emit),
    .result       (result)
  );

  // Output register. The sequencer only emits when out_free is high, so a loaded
  // result is never overwritten before its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      inner_fold      <= result.inner_fold;
      outer_fold      <= result.outer_fold;
      inner_remaining <= result.inner_remaining;
      outer_remaining <= result.outer_remaining;
      label_error     <= result.label_error;
    end
  end

endmodule

`default_nettype wire

@@ sim/stratified_fold_assigner_test.sv @@
`timescale 1ns / 1ps

module stratified_fold_assigner_test;
  import sfa_pkg::*;

  localparam int CLK_HALF      = 5;
  // A restart keeps the block busy without producing a transfer, so every settings
  // change waits for longer than a restart takes after the last result.
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_ITEMS  = 410;
  localparam int MAX_IDLE      = 18;

  typedef enum logic {
    MODE_RESTART = 1'b0,
    MODE_ASSIGN  = 1'b1
  } item_mode_t;

  // One row of the directed plan: either a register write or an item. Items whose
  // result is obvious carry it typed in; the others are checked by the predictor.
  typedef struct {
    bit                    is_write;
    cfg_reg_t              wr_index;
    logic [COUNT_BITS-1:0] wr_value;
    item_mode_t            item_mode;
    logic [LABEL_W-1:0]    label;
    bit                    known;
    result_t               want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write_en = 1'b0;
  logic [1:0]            cfg_index = '0;
  logic [COUNT_BITS-1:0] cfg_data = '0;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  logic                  mode = 1'b0;
  logic [LABEL_W-1:0]    class_label = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [FOLD_W-1:0]     inner_fold;
  logic [FOLD_W-1:0]     outer_fold;
  logic [COUNT_BITS-1:0] inner_remaining;
  logic [COUNT_BITS-1:0] outer_remaining;
  logic                  label_error;

  stratified_fold_assigner DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .mode            (mode),
    .class_label     (class_label),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .inner_fold      (inner_fold),
    .outer_fold      (outer_fold),
    .inner_remaining (inner_remaining),
    .outer_remaining (outer_remaining),
    .label_error     (label_error)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Shadow copy of the block: its four settings as last written, and the
  // per-label running offsets and per-fold remaining counts.
  int unsigned inner_setting = 1;
  int unsigned outer_setting = 1;
  int unsigned label_setting = 1;
  int unsigned total_setting = 0;
  int unsigned label_cursor [MAX_LABELS] = '{default: 0};
  int unsigned inner_left [MAX_FOLDS] = '{default: 0};
  int unsigned outer_left [MAX_FOLDS] = '{default: 0};

  // Fold assignments still owed by the block, oldest first.
  result_t fold_results_due [$];
  result_t oldest_due;

  int  mismatch_count = 0;
  int  results_seen = 0;
  int  results_paced = 0;
  int  stall_left = 0;
  int  cycle_count = 0;
  // When set, neither side idles, which gives back-to-back stretches.
  bit  calm = 1'b0;

  // A zero count behaves as one, and anything past the array size saturates.
  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic result_t fold_result(int unsigned fi, int unsigned fo, int unsigned ir,
                                          int unsigned orem, bit err);
    result_t r;
    r.inner_fold      = fi[FOLD_W-1:0];
    r.outer_fold      = fo[FOLD_W-1:0];
    r.inner_remaining = ir[COUNT_BITS-1:0];
    r.outer_remaining = orem[COUNT_BITS-1:0];
    r.label_error     = err;
    return r;
  endfunction

  // Works out what one accepted item does to the shadow state and which result,
  // if any, it produces. A restart refills the counts and seeds the offsets; an
  // assign with a known label reads and advances that label's offset.
  task automatic predict_fold_step(input item_mode_t m, input logic [LABEL_W-1:0] lab,
                                   output bit emits, output result_t r);
    int unsigned ni;
    int unsigned no;
    int unsigned nl;
    int unsigned nf;
    int unsigned stride;
    int unsigned inc;
    int unsigned off;
    int unsigned fi;
    int unsigned fo;
    ni     = clamp_size(inner_setting, MAX_FOLDS);
    no     = clamp_size(outer_setting, MAX_FOLDS);
    nl     = clamp_size(label_setting, MAX_LABELS);
    nf     = ni * no;
    stride = ni + 1;
    emits  = 1'b0;
    r      = '0;
    if (m == MODE_RESTART) begin
      inc = nf / nl;
      if (inc < 1) inc = 1;
      for (int k = 0; k < MAX_FOLDS; k++) begin
        inner_left[k] = total_setting;
        outer_left[k] = total_setting;
      end
      for (int k = 0; k < MAX_LABELS; k++) begin
        label_cursor[k] = (k < nl) ? (k * inc * stride) % nf : 0;
      end
    end else if (lab >= nl) begin
      // Unknown label: flagged, everything else zero, state untouched.
      emits = 1'b1;
      r     = fold_result(0, 0, 0, 0, 1'b1);
    end else begin
      // The stored offset may be stale if the fold counts changed without a
      // restart, so it is reduced before use.
      off = label_cursor[lab] % nf;
      fi  = off % ni;
      fo  = off / ni;
      if (inner_left[fi] > 0) inner_left[fi]--;
      if (no > 1 && outer_left[fo] > 0) outer_left[fo]--;
      label_cursor[lab] = (off + stride) % nf;
      emits = 1'b1;
      r     = fold_result(fi, fo, inner_left[fi], outer_left[fo], 1'b0);
    end
  endtask

  function automatic plan_row_t write_row(cfg_reg_t idx, logic [COUNT_BITS-1:0] value);
    plan_row_t row;
    row          = '{default: '0, wr_index: REG_INNER, item_mode: MODE_RESTART};
    row.is_write = 1'b1;
    row.wr_index = idx;
    row.wr_value = value;
    return row;
  endfunction

  function automatic plan_row_t item_row(item_mode_t m, logic [LABEL_W-1:0] lab);
    plan_row_t row;
    row           = '{default: '0, wr_index: REG_INNER, item_mode: MODE_RESTART};
    row.item_mode = m;
    row.label     = lab;
    return row;
  endfunction

  function automatic plan_row_t known_row(logic [LABEL_W-1:0] lab, result_t want);
    plan_row_t row;
    row       = item_row(MODE_ASSIGN, lab);
    row.known = 1'b1;
    row.want  = want;
    return row;
  endfunction

  // Presents one item after a random gap and holds it until the block takes it.
  // The shadow state is advanced at the moment of the transfer.
  task automatic send_item(input item_mode_t m, input logic [LABEL_W-1:0] lab,
                           input bit known = 1'b0, input result_t want = '0);
    int      gap;
    bit      emits;
    result_t r;
    gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
    @(negedge clk);
    cfg_write_en <= 1'b0;
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid  <= 1'b1;
    mode        <= m;
    class_label <= lab;
    do @(posedge clk); while (item_stall);
    predict_fold_step(m, lab, emits, r);
    if (emits) fold_results_due.push_back(known ? want : r);
  endtask

  // Drops valid, then waits for every owed result plus the restart latency, so
  // the block is idle afterwards even if the last item was a restart.
  task automatic drain_block();
    @(negedge clk);
    item_valid   <= 1'b0;
    cfg_write_en <= 1'b0;
    while (fold_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Single register write. The enable is left high; the next item or drain
  // lowers it, so back-to-back writes keep it up without a glitch.
  task automatic write_setting(input cfg_reg_t idx, input logic [COUNT_BITS-1:0] value);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= value;
    @(posedge clk);
    case (idx)
      REG_INNER:  inner_setting = value[CFG_W-1:0];
      REG_OUTER:  outer_setting = value[CFG_W-1:0];
      REG_LABELS: label_setting = value[CFG_W-1:0];
      REG_TOTAL:  total_setting = value;
      default: ;
    endcase
  endtask

  // Fold or label count for a random phase: mostly in range and small, sometimes
  // the maximum, one, zero or past the array size.
  function automatic logic [CFG_W-1:0] draw_size();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) return 5'd16;
    if (kind == 1) return $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
    if (kind == 2) return 5'd1;
    return 5'($urandom_range(1, $urandom_range(0, 1) ? 16 : 5));
  endfunction

  // Count registers only keep their low bits; the upper data bits are sometimes
  // filled with noise that must be ignored.
  function automatic logic [COUNT_BITS-1:0] size_word(logic [CFG_W-1:0] size);
    logic [COUNT_BITS-CFG_W-1:0] junk;
    junk = $urandom_range(0, 1) ? '0 : (COUNT_BITS-CFG_W)'($urandom);
    return {junk, size};
  endfunction

  function automatic logic [COUNT_BITS-1:0] draw_total();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return COUNT_BITS'($urandom_range(0, (1 << COUNT_BITS) - 1));
      default: return COUNT_BITS'($urandom_range(1, 40));
    endcase
  endfunction

  // Result side: after each transfer the receiver draws how long it stalls
  // before it is willing to take the next one.
  always @(negedge clk) begin
    if (results_seen != results_paced) begin
      results_paced = results_seen;
      stall_left    = calm ? 0 : $urandom_range(0, MAX_IDLE);
    end
    result_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left = stall_left - 1;
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Every result transfer is matched against the oldest owed fold assignment.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (fold_results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got inner %0d outer %0d err %0b",
                 $time, inner_fold, outer_fold, label_error);
        mismatch_count++;
      end else begin
        oldest_due = fold_results_due.pop_front();
        check_field("inner_fold", oldest_due.inner_fold, inner_fold);
        check_field("outer_fold", oldest_due.outer_fold, outer_fold);
        check_field("inner_remaining", oldest_due.inner_remaining, inner_remaining);
        check_field("outer_remaining", oldest_due.outer_remaining, outer_remaining);
        check_field("label_error", oldest_due.label_error, label_error);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still owed", $time, fold_results_due.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    plan_row_t   plan [$];
    int unsigned phase_items;
    int unsigned random_sent;
    int unsigned nl;
    logic [LABEL_W-1:0] lab;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. Right after reset everything is one fold and one label
    // with a zero total, so the first assign must give all zeros.
    plan.push_back(known_row(4'd0, fold_result(0, 0, 0, 0, 1'b0)));
    plan.push_back(known_row(4'd15, fold_result(0, 0, 0, 0, 1'b1)));
    plan.push_back(item_row(MODE_RESTART, 4'd10));
    plan.push_back(known_row(4'd0, fold_result(0, 0, 0, 0, 1'b0)));
    // Largest configuration with the largest total; label offsets step by 16.
    plan.push_back(write_row(REG_INNER, 20'd16));
    plan.push_back(write_row(REG_OUTER, 20'd16));
    plan.push_back(write_row(REG_LABELS, 20'd16));
    plan.push_back(write_row(REG_TOTAL, 20'hFFFFF));
    plan.push_back(item_row(MODE_RESTART, 4'd5));
    plan.push_back(known_row(4'd0, fold_result(0, 0, 20'hFFFFE, 20'hFFFFE, 1'b0)));
    plan.push_back(item_row(MODE_ASSIGN, 4'd15));
    plan.push_back(item_row(MODE_ASSIGN, 4'd15));
    plan.push_back(item_row(MODE_ASSIGN, 4'd7));
    // Zero counts behave as one; no restart, so the stored offsets are stale.
    plan.push_back(write_row(REG_INNER, 20'd0));
    plan.push_back(write_row(REG_OUTER, 20'd0));
    plan.push_back(write_row(REG_LABELS, 20'd0));
    plan.push_back(item_row(MODE_ASSIGN, 4'd0));
    plan.push_back(known_row(4'd1, fold_result(0, 0, 0, 0, 1'b1)));
    // Counts past the array size saturate; a total of one drives a fold's count
    // to zero and the next hit on it must stay at zero.
    plan.push_back(write_row(REG_INNER, 20'd31));
    plan.push_back(write_row(REG_OUTER, 20'd31));
    plan.push_back(write_row(REG_LABELS, 20'd31));
    plan.push_back(write_row(REG_TOTAL, 20'd1));
    plan.push_back(item_row(MODE_RESTART, 4'd0));
    plan.push_back(item_row(MODE_ASSIGN, 4'd3));
    plan.push_back(item_row(MODE_ASSIGN, 4'd0));
    // Outer split only, five labels: labels five and up are rejected.
    plan.push_back(write_row(REG_INNER, 20'd1));
    plan.push_back(write_row(REG_OUTER, 20'd16));
    plan.push_back(write_row(REG_LABELS, 20'd5));
    plan.push_back(write_row(REG_TOTAL, 20'd2));
    plan.push_back(item_row(MODE_RESTART, 4'd15));
    plan.push_back(item_row(MODE_ASSIGN, 4'd4));
    plan.push_back(known_row(4'd5, fold_result(0, 0, 0, 0, 1'b1)));
    plan.push_back(known_row(4'd15, fold_result(0, 0, 0, 0, 1'b1)));
    // A single outer fold never has its outer count lowered.
    plan.push_back(write_row(REG_INNER, 20'd4));
    plan.push_back(write_row(REG_OUTER, 20'd1));
    plan.push_back(write_row(REG_LABELS, 20'd2));
    plan.push_back(write_row(REG_TOTAL, 20'd3));
    plan.push_back(item_row(MODE_RESTART, 4'd0));
    plan.push_back(item_row(MODE_ASSIGN, 4'd0));
    plan.push_back(item_row(MODE_ASSIGN, 4'd1));

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        drain_block();
        write_setting(plan[i].wr_index, plan[i].wr_value);
      end else begin
        send_item(plan[i].item_mode, plan[i].label, plan[i].known, plan[i].want);
      end
    end

    // Random part, in phases. Each phase picks new settings while the block is
    // idle, usually restarts, then runs a burst of mostly valid assigns and occasional restarts.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      drain_block();
      if ($urandom_range(0, 3) != 0) write_setting(REG_INNER, size_word(draw_size()));
      if ($urandom_range(0, 3) != 0) write_setting(REG_OUTER, size_word(draw_size()));
      if ($urandom_range(0, 3) != 0) write_setting(REG_LABELS, size_word(draw_size()));
      if ($urandom_range(0, 3) != 0) write_setting(REG_TOTAL, draw_total());
      calm = ($urandom_range(0, 3) == 0);
      // Skipping the restart now and then exercises stale offsets.
      if ($urandom_range(0, 4) != 0) begin
        send_item(MODE_RESTART, LABEL_W'($urandom));
        random_sent++;
      end
      phase_items = $urandom_range(15, 45);
      nl          = clamp_size(label_setting, MAX_LABELS);
      repeat (phase_items) begin
        // Now and then the sender holds off until every owed result is back.
        if ($urandom_range(0, 24) == 0) begin
          @(negedge clk);
          item_valid <= 1'b0;
          while (fold_results_due.size() != 0) @(posedge clk);
        end
        if ($urandom_range(0, 19) == 0) begin
          send_item(MODE_RESTART, LABEL_W'($urandom));
        end else begin
          lab = ($urandom_range(0, 9) == 0) ? LABEL_W'($urandom_range(0, 15))
                                             : LABEL_W'($urandom_range(0, nl - 1));
          send_item(MODE_ASSIGN, lab);
        end
        random_sent++;
      end
    end

    calm = 1'b0;
    drain_block();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
